[hdl/gm2g_pkg.sv]
// gm2g_pkg: shared types, constants and the exp2 table for the 2d gaussian gradient block
// no dependencies; used by gm2g_div and gaussian_2d_model_gradient
package gm2g_pkg;

  // fixed-point layout
  localparam int EXP_TABLE_BITS = 8;
  localparam int TABLE_LEN      = (1 << EXP_TABLE_BITS) + 1;
  localparam int ARG_FRAC       = 24;
  localparam int REM_BITS       = ARG_FRAC - EXP_TABLE_BITS;
  localparam int Z_BITS         = 16;
  localparam int Z_CUTOFF       = 17;
  localparam int T_BITS         = 29;
  localparam int DIV_STEPS      = 32;
  localparam int DIV_LAT        = DIV_STEPS + 1;

  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [20:0] RATIO_CLAMP = 21'h100000;

  // configuration register indexes
  localparam logic [2:0] REG_AMPLITUDE = 3'd0;
  localparam logic [2:0] REG_CENTER_X  = 3'd1;
  localparam logic [2:0] REG_SPREAD    = 3'd2;
  localparam logic [2:0] REG_CENTER_Y  = 3'd3;
  localparam logic [2:0] REG_BASELINE  = 3'd4;

  // reset values
  localparam logic [31:0] AMPLITUDE_RST = 32'h0001_0000;
  localparam logic [30:0] SPREAD_RST    = 31'h0001_0000;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } in_t;

  typedef struct packed {
    logic [31:0] model_value;
    logic [16:0] grad_amplitude;
    logic [31:0] grad_center_x;
    logic [31:0] grad_spread;
    logic [31:0] grad_center_y;
    logic        saturated;
  } out_t;

  typedef logic [32:0] pow_tab_t [TABLE_LEN];

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-i/2^EXP_TABLE_BITS) in Q1.32, from repeated square roots of one half
  function automatic pow_tab_t build_pow_table();
    logic [63:0] roots [EXP_TABLE_BITS+1];
    logic [63:0] v;
    pow_tab_t    tab;
    roots[EXP_TABLE_BITS] = 64'd1 << 31;
    for (int k = EXP_TABLE_BITS - 1; k >= 0; k--) begin
      roots[k] = isqrt64(roots[k+1] << 32);
    end
    for (int i = 0; i < TABLE_LEN; i++) begin
      v = 64'd1 << 32;
      for (int k = 0; k <= EXP_TABLE_BITS; k++) begin
        if (((i >> k) & 1) != 0) v = (v * roots[k]) >> 32;
      end
      tab[i] = v[32:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TABLE = build_pow_table();

endpackage

[hdl/gm2g_div.sv]
// gm2g_div: pipelined restoring divider, one quotient bit per stage
// 64-bit dividend, 31-bit divisor, 32-bit quotient with overflow flag; uses gm2g_pkg
module gm2g_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [30:0] den_i,
  output logic [31:0] quo_o,
  output logic        ovf_o
);
  import gm2g_pkg::*;

  logic [63:0]          rem_q [DIV_STEPS];
  logic [30:0]          den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic                 ovf_q [DIV_STEPS+1];

  // entry stage: quotient overflows when the dividend reaches den * 2^32
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_i >= {1'b0, den_i, 32'd0});
    end
  end

  // one trial subtract per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int Sh = DIV_STEPS - 1 - j;
    logic [63:0] trial;
    logic        ge;

    assign trial = {33'd0, den_q[j]} << Sh;
    assign ge    = (rem_q[j] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= {quo_q[j][DIV_STEPS-2:0], ge};
        ovf_q[j+1] <= ovf_q[j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? (rem_q[j] - trial) : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS];
  assign ovf_o = ovf_q[DIV_STEPS];

endmodule

[hdl/gaussian_2d_model_gradient.sv]
// gaussian_2d_model_gradient: circular 2d gaussian with offset and its partials
// depends on gm2g_pkg and gm2g_div
//
//   channel   | signals                               | word
//   ----------+---------------------------------------+------------------------
//   input     | in_valid_i, in_stall_o, in_data_i     | sample point pos_x/pos_y
//   output    | out_valid_o, out_stall_i, out_data_o  | model value, partials, flag
//   config    | cfg_we_i, cfg_index_i, cfg_data_i     | one register per write
//
// one word enters per cycle while in_stall_o is low; a taken word passes through the input
// stage, which loads on the edge that takes it, then the two 33-stage divider
// pipelines (ratio by spread, partials by spread), nine arithmetic stages between them
// and the output queue
// reset is asynchronous and active low; it clears the valid bits and loads register defaults
// the whole pipeline advances together; a two-entry output queue keeps taking words
// while one result waits, and stall goes high only when the queue holds two
module gaussian_2d_model_gradient (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gm2g_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gm2g_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import gm2g_pkg::*;

  typedef struct packed {
    logic [31:0] model;
    logic        mflag;
    logic [16:0] z16;
    logic        negx;
    logic        negs;
    logic        negy;
  } side_t;

  // configuration registers
  logic [31:0] amp_q, cx_q, cy_q, base_q;
  logic [30:0] spread_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q    <= AMPLITUDE_RST;
      cx_q     <= '0;
      spread_q <= SPREAD_RST;
      cy_q     <= '0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AMPLITUDE: amp_q    <= cfg_data_i;
        REG_CENTER_X:  cx_q     <= cfg_data_i;
        REG_SPREAD:    spread_q <= cfg_data_i[30:0];
        REG_CENTER_Y:  cy_q     <= cfg_data_i;
        REG_BASELINE:  base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero spread acts as the smallest positive value
  logic [30:0] w_eff, half_w;
  assign w_eff  = (spread_q == 31'd0) ? 31'd1 : spread_q;
  assign half_w = {1'b0, w_eff[30:1]};

  logic        nega;
  logic [31:0] amag;
  assign nega = amp_q[31];
  assign amag = nega ? (32'd0 - amp_q) : amp_q;

  // pipeline advance and handshake
  logic       en, push, pop;
  logic [1:0] cnt_q;
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = ~en;

  // stage 1: offsets from the centre as magnitude and sign
  logic [32:0] dx_c, dy_c, mx_c, my_c;
  assign dx_c = {in_data_i.pos_x[31], in_data_i.pos_x} - {cx_q[31], cx_q};
  assign dy_c = {in_data_i.pos_y[31], in_data_i.pos_y} - {cy_q[31], cy_q};
  assign mx_c = dx_c[32] ? (33'd0 - dx_c) : dx_c;
  assign my_c = dy_c[32] ? (33'd0 - dy_c) : dy_c;

  logic        v1_q, negx1_q, negy1_q;
  logic [32:0] mx1_q, my1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx1_q   <= mx_c;
      my1_q   <= my_c;
      negx1_q <= dx_c[32];
      negy1_q <= dy_c[32];
    end
  end

  // ratio dividers: round(|d| * 2^16 / w)
  logic [63:0] rnum_x, rnum_y;
  logic [31:0] rq_x, rq_y;
  logic        rovf_x, rovf_y;
  assign rnum_x = {15'd0, mx1_q, 16'd0} + {33'd0, half_w};
  assign rnum_y = {15'd0, my1_q, 16'd0} + {33'd0, half_w};

  gm2g_div u_div_rx (
    .clk_i (clk_i), .en_i (en), .num_i (rnum_x), .den_i (w_eff),
    .quo_o (rq_x), .ovf_o (rovf_x)
  );
  gm2g_div u_div_ry (
    .clk_i (clk_i), .en_i (en), .num_i (rnum_y), .den_i (w_eff),
    .quo_o (rq_y), .ovf_o (rovf_y)
  );

  // signs and valid alongside the ratio dividers
  logic [DIV_LAT-1:0] rv_q;
  logic [1:0]         rs_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= '0;
    else if (en) rv_q <= {rv_q[DIV_LAT-2:0], v1_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q[0] <= {negx1_q, negy1_q};
      for (int k = 1; k < DIV_LAT; k++) rs_q[k] <= rs_q[k-1];
    end
  end

  // stage 3: clip ratios and square them
  logic [20:0] qx_c, qy_c;
  assign qx_c = (rovf_x || rq_x > 32'(RATIO_CLAMP)) ? RATIO_CLAMP : rq_x[20:0];
  assign qy_c = (rovf_y || rq_y > 32'(RATIO_CLAMP)) ? RATIO_CLAMP : rq_y[20:0];

  logic        v3_q, negx3_q, negy3_q;
  logic [20:0] qx3_q, qy3_q;
  logic [41:0] sqx3_q, sqy3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx3_q   <= qx_c;
      qy3_q   <= qy_c;
      sqx3_q  <= qx_c * qx_c;
      sqy3_q  <= qy_c * qy_c;
      negx3_q <= rs_q[DIV_LAT-1][1];
      negy3_q <= rs_q[DIV_LAT-1][0];
    end
  end

  // stage 4: squared distance in q32
  logic        v4_q, negx4_q, negy4_q;
  logic [20:0] qx4_q, qy4_q;
  logic [41:0] sq4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq4_q   <= sqx3_q + sqy3_q;
      qx4_q   <= qx3_q;
      qy4_q   <= qy3_q;
      negx4_q <= negx3_q;
      negy4_q <= negy3_q;
    end
  end

  // stage 5: half distance in q24 times log2(e); far when it cannot give z above zero
  logic [32:0] t24_c;
  logic [42:0] kr_c;
  assign t24_c = sq4_q[41:9];
  assign kr_c  = {1'b0, sq4_q} + 43'h8000;

  logic        v5_q, far5_q, negx5_q, negy5_q;
  logic [20:0] qx5_q, qy5_q;
  logic [25:0] k5_q;
  logic [59:0] sp5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp5_q   <= t24_c[T_BITS-1:0] * LOG2E_Q30;
      far5_q  <= (t24_c[32:T_BITS] != '0);
      k5_q    <= kr_c[41:16];
      qx5_q   <= qx4_q;
      qy5_q   <= qy4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
    end
  end

  // stage 6: table lookup and interpolation product
  logic [29:0]               s_c;
  logic [5:0]                n_c;
  logic [EXP_TABLE_BITS-1:0] idx_c;
  logic [EXP_TABLE_BITS:0]   idx1_c;
  logic [REM_BITS-1:0]       rem_c;
  logic [32:0]               hi_c, lo_c, diff_c;
  assign s_c    = sp5_q[59:30];
  assign n_c    = s_c[29:ARG_FRAC];
  assign idx_c  = s_c[ARG_FRAC-1 -: EXP_TABLE_BITS];
  assign idx1_c = {1'b0, idx_c} + (EXP_TABLE_BITS+1)'(1);
  assign rem_c  = s_c[REM_BITS-1:0];
  assign hi_c   = POW_TABLE[idx_c];
  assign lo_c   = POW_TABLE[idx1_c];
  assign diff_c = hi_c - lo_c;

  logic                 v6_q, far6_q, negx6_q, negy6_q;
  logic [32:0]          hi6_q;
  logic [33+REM_BITS-1:0] dp6_q;
  logic [4:0]           n6_q;
  logic [20:0]          qx6_q, qy6_q;
  logic [25:0]          k6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hi6_q   <= hi_c;
      dp6_q   <= diff_c * rem_c;
      n6_q    <= n_c[4:0];
      far6_q  <= far5_q | (n_c >= 6'(Z_CUTOFF));
      k6_q    <= k5_q;
      qx6_q   <= qx5_q;
      qy6_q   <= qy5_q;
      negx6_q <= negx5_q;
      negy6_q <= negy5_q;
    end
  end

  // stage 7: interpolated fraction power
  logic        v7_q, far7_q, negx7_q, negy7_q;
  logic [32:0] zf7_q;
  logic [4:0]  n7_q;
  logic [20:0] qx7_q, qy7_q;
  logic [25:0] k7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zf7_q   <= hi6_q - dp6_q[33+REM_BITS-1:REM_BITS];
      n7_q    <= n6_q;
      far7_q  <= far6_q;
      k7_q    <= k6_q;
      qx7_q   <= qx6_q;
      qy7_q   <= qy6_q;
      negx7_q <= negx6_q;
      negy7_q <= negy6_q;
    end
  end

  // stage 8: integer power shift, round to q1.16
  logic [33:0] zr_c;
  assign zr_c = {1'b0, zf7_q >> n7_q} + 34'h8000;

  logic        v8_q, negx8_q, negy8_q;
  logic [16:0] z8_q;
  logic [20:0] qx8_q, qy8_q;
  logic [25:0] k8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z8_q    <= far7_q ? 17'd0 : zr_c[32:Z_BITS];
      k8_q    <= k7_q;
      qx8_q   <= qx7_q;
      qy8_q   <= qy7_q;
      negx8_q <= negx7_q;
      negy8_q <= negy7_q;
    end
  end

  // stage 9: |A| * z
  logic        v9_q, negx9_q, negy9_q;
  logic [48:0] azp9_q;
  logic [16:0] z9_q;
  logic [20:0] qx9_q, qy9_q;
  logic [25:0] k9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      azp9_q  <= amag * z8_q;
      z9_q    <= z8_q;
      k9_q    <= k8_q;
      qx9_q   <= qx8_q;
      qy9_q   <= qy8_q;
      negx9_q <= negx8_q;
      negy9_q <= negy8_q;
    end
  end

  // stage 10: round |A|*z to q16.16
  logic [48:0] azr_c;
  assign azr_c = azp9_q + 49'h8000;

  logic        v10_q, negx10_q, negy10_q;
  logic [31:0] az10_q;
  logic [16:0] z10_q;
  logic [20:0] qx10_q, qy10_q;
  logic [25:0] k10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      az10_q   <= azr_c[47:16];
      z10_q    <= z9_q;
      k10_q    <= k9_q;
      qx10_q   <= qx9_q;
      qy10_q   <= qy9_q;
      negx10_q <= negx9_q;
      negy10_q <= negy9_q;
    end
  end

  // stage 11: partial numerators and the saturated model value
  logic [33:0] msum_c;
  logic [31:0] model_c;
  logic        mflag_c;
  assign msum_c = (nega ? (34'd0 - {2'b00, az10_q}) : {2'b00, az10_q})
                  + {{2{base_q[31]}}, base_q};

  always_comb begin
    mflag_c = 1'b0;
    model_c = msum_c[31:0];
    if (msum_c[33] && (msum_c[32:31] != 2'b11)) begin
      mflag_c = 1'b1;
      model_c = 32'h8000_0000;
    end else if (!msum_c[33] && (msum_c[32:31] != 2'b00)) begin
      mflag_c = 1'b1;
      model_c = 32'h7FFF_FFFF;
    end
  end

  logic        v11_q;
  logic [52:0] px11_q, py11_q;
  logic [57:0] pk11_q;
  side_t       side11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px11_q         <= az10_q * qx10_q;
      py11_q         <= az10_q * qy10_q;
      pk11_q         <= az10_q * k10_q;
      side11_q.model <= model_c;
      side11_q.mflag <= mflag_c;
      side11_q.z16   <= z10_q;
      side11_q.negx  <= nega ^ negx10_q;
      side11_q.negs  <= nega;
      side11_q.negy  <= nega ^ negy10_q;
    end
  end

  // valid bits through stages 3 to 11
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q} <= '0;
    end else if (en) begin
      v3_q  <= rv_q[DIV_LAT-1];
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  // partial dividers: round(num / w)
  logic [63:0] gnum_x, gnum_s, gnum_y;
  logic [31:0] gq_x, gq_s, gq_y;
  logic        govf_x, govf_s, govf_y;
  assign gnum_x = {11'd0, px11_q} + {33'd0, half_w};
  assign gnum_s = {6'd0, pk11_q} + {33'd0, half_w};
  assign gnum_y = {11'd0, py11_q} + {33'd0, half_w};

  gm2g_div u_div_gx (
    .clk_i (clk_i), .en_i (en), .num_i (gnum_x), .den_i (w_eff),
    .quo_o (gq_x), .ovf_o (govf_x)
  );
  gm2g_div u_div_gs (
    .clk_i (clk_i), .en_i (en), .num_i (gnum_s), .den_i (w_eff),
    .quo_o (gq_s), .ovf_o (govf_s)
  );
  gm2g_div u_div_gy (
    .clk_i (clk_i), .en_i (en), .num_i (gnum_y), .den_i (w_eff),
    .quo_o (gq_y), .ovf_o (govf_y)
  );

  // model value, z and signs alongside the partial dividers
  logic [DIV_LAT-1:0] gv_q;
  side_t              gs_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gv_q <= '0;
    else if (en) gv_q <= {gv_q[DIV_LAT-2:0], v11_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gs_q[0] <= side11_q;
      for (int k = 1; k < DIV_LAT; k++) gs_q[k] <= gs_q[k-1];
    end
  end

  // signed saturation of a magnitude quotient; flag in the top bit
  function automatic logic [32:0] sat_grad(input logic [31:0] q, input logic ovf,
                                           input logic neg);
    logic [31:0] m;
    logic        f;
    m = q;
    f = 1'b0;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) begin
        f = 1'b1;
        m = 32'h8000_0000;
      end
      m = 32'd0 - m;
    end else if (ovf || q > 32'h7FFF_FFFF) begin
      f = 1'b1;
      m = 32'h7FFF_FFFF;
    end
    return {f, m};
  endfunction

  // final assembly
  side_t       fin_side;
  logic [32:0] sat_x, sat_s, sat_y;
  out_t        res_c;
  assign fin_side = gs_q[DIV_LAT-1];
  assign sat_x    = sat_grad(gq_x, govf_x, fin_side.negx);
  assign sat_s    = sat_grad(gq_s, govf_s, fin_side.negs);
  assign sat_y    = sat_grad(gq_y, govf_y, fin_side.negy);

  always_comb begin
    res_c.model_value    = fin_side.model;
    res_c.grad_amplitude = fin_side.z16;
    res_c.grad_center_x  = sat_x[31:0];
    res_c.grad_spread    = sat_s[31:0];
    res_c.grad_center_y  = sat_y[31:0];
    res_c.saturated      = fin_side.mflag | sat_x[32] | sat_s[32] | sat_y[32];
  end

  // two-entry output queue
  out_t fifo_q [2];
  logic wr_q, rd_q;

  assign push        = en & gv_q[DIV_LAT-1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_data_o  = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= res_c;
  end

endmodule

[tb/sv/gaussian_2d_model_gradient_tb.sv]
// gaussian_2d_model_gradient_tb: self-checking testbench for the 2d gaussian gradient block
// depends on gm2g_pkg and gaussian_2d_model_gradient; predicts every result word in fixed point
// and checks it field by field under random input gaps and output stalls
`timescale 1ns / 1ps

module gaussian_2d_model_gradient_tb;
  import gm2g_pkg::*;

  localparam int GAP_MAX   = 13;
  localparam int SETTLE    = 90;
  localparam int WDOG_MAX  = 3000;
  localparam int RAND_ITEMS = 440;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // predictor copy of the configuration
  logic [31:0] amp_r;
  logic [31:0] cx_r;
  logic [30:0] spread_r;
  logic [31:0] cy_r;
  logic [31:0] base_r;

  longint unsigned exp2_lut [TABLE_LEN];
  out_t            gauss_expect_q [$];
  int              mismatches;
  int              idle_cycles;
  bit              no_gaps;
  int              out_hold;
  bit              out_take;
  out_t            out_seen;

  gaussian_2d_model_gradient DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bitwise square root for the exp2 table
  function automatic longint unsigned root_of(longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-i/256) in q1.32 from repeated roots of one half
  task automatic fill_exp2_lut();
    longint unsigned roots [EXP_TABLE_BITS+1];
    longint unsigned v;
    roots[EXP_TABLE_BITS] = 64'd1 << 31;
    for (int k = EXP_TABLE_BITS - 1; k >= 0; k--) roots[k] = root_of(roots[k+1] << 32);
    for (int i = 0; i < TABLE_LEN; i++) begin
      v = 64'd1 << 32;
      for (int k = 0; k <= EXP_TABLE_BITS; k++)
        if (((i >> k) & 1) != 0) v = (v * roots[k]) >> 32;
      exp2_lut[i] = v;
    end
  endtask

  function automatic longint unsigned ratio_q16(longint unsigned m, longint unsigned w);
    longint unsigned q;
    q = ((m << 16) + w / 2) / w;
    return (q > (64'd1 << 20)) ? (64'd1 << 20) : q;
  endfunction

  // magnitude plus sign to 32 bit two's complement, clipping sets the flag
  function automatic logic [31:0] clip32(longint unsigned m, bit neg, ref bit flag);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        flag = 1'b1;
        m = 64'h8000_0000;
      end
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) begin
      flag = 1'b1;
      m = 64'h7FFF_FFFF;
    end
    return 32'(m);
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // expected result word for one sample point under the current registers
  function automatic out_t gauss_predict(in_t p);
    out_t            o;
    bit              flag;
    longint          a;
    longint          dx;
    longint          dy;
    longint          model;
    longint unsigned w, qx, qy, sq, t24, s, z16, n, f, idx, rem, hi, lo, zf, az, k16;
    flag = 1'b0;
    a  = longint'($signed(amp_r));
    dx = longint'($signed(p.pos_x)) - longint'($signed(cx_r));
    dy = longint'($signed(p.pos_y)) - longint'($signed(cy_r));
    w  = longint'(spread_r);
    if (w == 0) w = 1;
    qx  = ratio_q16(mag(dx), w);
    qy  = ratio_q16(mag(dy), w);
    sq  = qx * qx + qy * qy;
    t24 = sq >> 9;
    s   = (t24 * longint'(LOG2E_Q30)) >> 30;
    z16 = 0;
    if ((s >> ARG_FRAC) < Z_CUTOFF) begin
      n   = s >> ARG_FRAC;
      f   = s & ((64'd1 << ARG_FRAC) - 1);
      idx = (f >> REM_BITS) & ((64'd1 << EXP_TABLE_BITS) - 1);
      rem = f & ((64'd1 << REM_BITS) - 1);
      hi  = exp2_lut[idx];
      lo  = exp2_lut[idx+1];
      zf  = hi - (((hi - lo) * rem) >> REM_BITS);
      z16 = ((zf >> n) + (64'd1 << 15)) >> 16;
    end
    k16 = (sq + (64'd1 << 15)) >> 16;
    az  = (mag(a) * z16 + (64'd1 << 15)) >> 16;
    model = ((a < 0) ? -longint'(az) : longint'(az)) + longint'($signed(base_r));
    o.model_value    = clip32(mag(model), model < 0, flag);
    o.grad_amplitude = 17'(z16);
    o.grad_center_x  = clip32((az * qx + w / 2) / w, (a < 0) != (dx < 0), flag);
    o.grad_spread    = clip32((az * k16 + w / 2) / w, a < 0, flag);
    o.grad_center_y  = clip32((az * qy + w / 2) / w, (a < 0) != (dy < 0), flag);
    o.saturated      = flag;
    return o;
  endfunction

  // register write; predictor registers follow the same index map
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_AMPLITUDE: amp_r    = val;
      REG_CENTER_X:  cx_r     = val;
      REG_SPREAD:    spread_r = val[30:0];
      REG_CENTER_Y:  cy_r     = val;
      REG_BASELINE:  base_r   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    while (gauss_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_model(logic [31:0] amp, logic [31:0] cx, logic [31:0] sp,
                           logic [31:0] cy, logic [31:0] base);
    drain();
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_SPREAD, sp);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_BASELINE, base);
  endtask

  // send one sample point, record its prediction at acceptance
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int gap;
    in_t p;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    p.pos_x = x;
    p.pos_y = y;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    gauss_expect_q.push_back(gauss_predict(p));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // point within a few spreads of the centre
  function automatic logic [31:0] near_coord(logic [31:0] c);
    longint w;
    longint off;
    w   = (spread_r == 0) ? 1 : longint'(spread_r);
    off = (w * (longint'($urandom_range(0, 8191)) - 4096)) >>> 10;
    return 32'(longint'($signed(c)) + off);
  endfunction

  task automatic test_reset_defaults();
    send_point(32'h0, 32'h0);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h0000_8000, 32'h0002_0000);
    send_point(32'h0006_0000, 32'h0000_0000);
    end_burst();
  endtask

  task automatic test_field_extremes();
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h0000_0007, 32'h0000_0000);
    end_burst();
    // negative peak with the centres at opposite ends of the range
    set_model(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_8000, 32'h8000_8000);
    end_burst();
  endtask

  task automatic test_special_cases();
    // overflow of model value and partials
    set_model(32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(32'hFFFF_FFFF, 32'h0000_0002);
    end_burst();
    // zero spread behaves as the smallest width; writes past the last register are dropped
    set_model(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0);
    send_point(32'h0000_0001, 32'h0);
    send_point(32'h0001_0000, 32'h0001_0000);
    end_burst();
    // widest spread: far points, clipped ratio never reached, z about exp(-1) and exp(-1/2)
    set_model(32'h0010_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFF0_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h0);
    end_burst();
    // far point and clipped ratio with unit spread
    set_model(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_point(32'h0005_0000, 32'h0003_0000);
    send_point(32'h0020_0000, 32'h0);
    end_burst();
  endtask

  task automatic test_random_fits();
    int sent;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 4))
        0: set_model($urandom, $urandom, $urandom, $urandom, $urandom);
        1: set_model($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                     $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                     $urandom_range(1, 32'h0008_0000),
                     $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                     $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
        2: set_model($urandom, $urandom, $urandom_range(0, 16), $urandom, $urandom);
        default: set_model($urandom, $urandom_range(0, 32'h0100_0000),
                           $urandom_range(32'h0000_4000, 32'h0040_0000),
                           $urandom, $urandom_range(0, 32'h0001_0000));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 40 && sent < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 4) == 0) send_point($urandom, $urandom);
        else send_point(near_coord(cx_r), near_coord(cy_r));
        sent++;
      end
      end_burst();
      no_gaps = 1'b0;
    end
  endtask

  // result side: random stalls, sample at falling edge, compare on acceptance
  always @(posedge clk_i) begin
    if (out_take) begin
      if (gauss_expect_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_seen);
        mismatches++;
      end else begin
        out_t e;
        e = gauss_expect_q.pop_front();
        if (e.model_value !== out_seen.model_value) begin
          $display("%0t: model_value expected %h actual %h", $realtime,
                   e.model_value, out_seen.model_value);
          mismatches++;
        end
        if (e.grad_amplitude !== out_seen.grad_amplitude) begin
          $display("%0t: grad_amplitude expected %h actual %h", $realtime,
                   e.grad_amplitude, out_seen.grad_amplitude);
          mismatches++;
        end
        if (e.grad_center_x !== out_seen.grad_center_x) begin
          $display("%0t: grad_center_x expected %h actual %h", $realtime,
                   e.grad_center_x, out_seen.grad_center_x);
          mismatches++;
        end
        if (e.grad_spread !== out_seen.grad_spread) begin
          $display("%0t: grad_spread expected %h actual %h", $realtime,
                   e.grad_spread, out_seen.grad_spread);
          mismatches++;
        end
        if (e.grad_center_y !== out_seen.grad_center_y) begin
          $display("%0t: grad_center_y expected %h actual %h", $realtime,
                   e.grad_center_y, out_seen.grad_center_y);
          mismatches++;
        end
        if (e.saturated !== out_seen.saturated) begin
          $display("%0t: saturated expected %b actual %b", $realtime,
                   e.saturated, out_seen.saturated);
          mismatches++;
        end
      end
      out_hold = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    end
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_take = rst_ni && out_valid_o && !out_stall_i;
    out_seen = out_data_o;
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (out_take || (in_valid_i && !in_stall_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("gaussian_2d_model_gradient test failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    out_hold    = 0;
    out_take    = 1'b0;
    amp_r       = AMPLITUDE_RST;
    cx_r        = '0;
    spread_r    = SPREAD_RST;
    cy_r        = '0;
    base_r      = '0;
    fill_exp2_lut();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_random_fits();

    drain();
    if (mismatches == 0) begin
      $display("gaussian_2d_model_gradient test passed");
    end else begin
      $display("gaussian_2d_model_gradient test failed");
    end
    $finish;
  end

endmodule
